>>> sv/apac_pkg.sv
package apac_pkg;

    localparam int CNT_W = 7;
    localparam int SUM_W = 24;
    localparam int ACC_W = 16;
    localparam int THR_W = 15;
    localparam int TAN_W = 12;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_GRAVITY = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MOVE    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_STILL   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TANGENT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SIDE    = 3'd4;

    localparam logic [THR_W-1:0] GRAVITY_RST = 15'd2511;
    localparam logic [THR_W-1:0] MOVE_RST    = 15'd461;
    localparam logic [THR_W-1:0] STILL_RST   = 15'd64;
    localparam logic [TAN_W-1:0] TANGENT_RST = 12'd119;
    localparam logic [THR_W-1:0] SIDE_RST    = 15'd1920;

    localparam logic [1:0] BEH_GRAZING  = 2'd0;
    localparam logic [1:0] BEH_STANDING = 2'd1;
    localparam logic [1:0] BEH_MOVING   = 2'd2;
    localparam logic [1:0] BEH_SIDE     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_ACC,
        ST_CAL_DIV,
        ST_CAL_FIN,
        ST_COR,
        ST_SQR,
        ST_SUM,
        ST_MOVE_HI,
        ST_MOVE_LO,
        ST_STILL_HI,
        ST_STILL_LO,
        ST_GRZ_LO,
        ST_GRZ_HI,
        ST_DECIDE,
        ST_OUT
    } st_t;

    typedef struct packed {
        logic clr;
        logic acc;
        logic div;
        logic fin;
        logic cor;
        logic sqr;
    } lane_ctrl_t;

endpackage

>>> sv/apac_axis_lane.sv
module apac_axis_lane
    import apac_pkg::*;
#(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_ctrl_t              ctrl,
    input  logic signed [ACC_W-1:0] sample,
    input  logic [THR_W-1:0]        bias,
    output logic signed [ACC_W-1:0] corr,
    output logic [30:0]             sq
);

    // floor(m / N) == (m * ceil(2^30 / N)) >> 30 for m * N < 2^30
    localparam int     DIV_SHIFT = 30;
    localparam longint RECIP_L   = ((longint'(1) << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [30:0] RECIP = 31'(RECIP_L);
    localparam logic [21:0] HALF  = 22'(CAL_SAMPLES / 2);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ACC_W-1:0] off_reg, off_next;
    logic signed [ACC_W-1:0] corr_reg, corr_next;
    logic [30:0]             sq_reg, sq_next;
    logic [52:0]             prod_reg, prod_next;
    logic                    neg_reg, neg_next;

    logic [SUM_W-1:0]        mag;
    logic [21:0]             mag_rnd;
    logic signed [17:0]      quo;
    logic signed [17:0]      avg;
    logic signed [17:0]      avg_b;
    logic signed [16:0]      dif;
    logic signed [31:0]      sq_full;

    always_comb begin
        mag     = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        mag_rnd = mag[21:0] + HALF;
        quo     = {1'b0, prod_reg[46:30]};
        avg     = neg_reg ? -quo : quo;
        avg_b   = avg - 18'($signed({1'b0, bias}));
        dif     = 17'(sample) - 17'(off_reg);
        sq_full = corr_reg * corr_reg;
    end

    always_comb begin
        sum_next  = sum_reg;
        off_next  = off_reg;
        corr_next = corr_reg;
        sq_next   = sq_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        if (ctrl.clr) begin
            sum_next = '0;
        end else if (ctrl.acc) begin
            sum_next = sum_reg + SUM_W'(sample);
        end
        if (ctrl.div) begin
            prod_next = 53'(mag_rnd) * 53'(RECIP);
            neg_next  = sum_reg[SUM_W-1];
        end
        if (ctrl.fin) begin
            if (avg_b > 18'sd32767) begin
                off_next = 16'sh7fff;
            end else if (avg_b < -18'sd32768) begin
                off_next = 16'sh8000;
            end else begin
                off_next = avg_b[15:0];
            end
        end
        if (ctrl.cor) begin
            if (dif > 17'sd32767) begin
                corr_next = 16'sh7fff;
            end else if (dif < -17'sd32768) begin
                corr_next = 16'sh8000;
            end else begin
                corr_next = dif[15:0];
            end
        end
        if (ctrl.sqr) begin
            sq_next = sq_full[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            off_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            off_reg <= off_next;
        end
        corr_reg <= corr_next;
        sq_reg   <= sq_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    assign corr = corr_reg;
    assign sq   = sq_reg;

endmodule

>>> sv/apac_merge.sv
module apac_merge
    import apac_pkg::*;
(
    input  logic                    aclk,
    input  st_t                     step,
    input  logic [30:0]             sq_x,
    input  logic [30:0]             sq_y,
    input  logic [30:0]             sq_z,
    input  logic                    x_neg,
    input  logic signed [ACC_W-1:0] corr_y,
    input  logic [THR_W-1:0]        gravity,
    input  logic [THR_W-1:0]        move_thr,
    input  logic [THR_W-1:0]        still_thr,
    input  logic [TAN_W-1:0]        tangent,
    input  logic [THR_W-1:0]        side_thr,
    output logic [1:0]              code
);

    logic [32:0] s_reg, s_next;
    logic [31:0] yz_reg, yz_next;
    logic [23:0] t2_reg, t2_next;
    logic [40:0] prod_reg, prod_next;
    logic [39:0] grz_lo_reg, grz_lo_next;
    logic        mv_hi_reg, mv_hi_next;
    logic        mv_lo_reg, mv_lo_next;
    logic        st_hi_reg, st_hi_next;
    logic        st_lo_reg, st_lo_next;
    logic [1:0]  code_reg, code_next;

    logic [23:0] mul_a;
    logic [16:0] mul_b;
    logic [15:0] g_plus_m, g_minus_m, g_plus_st, g_minus_st;
    logic [40:0] s_ext;
    logic [55:0] rhs, lhs;
    logic [16:0] y_ext, y_abs;
    logic        grazing;

    always_comb begin
        g_plus_m   = {1'b0, gravity} + {1'b0, move_thr};
        g_minus_m  = (gravity > move_thr) ? ({1'b0, gravity} - {1'b0, move_thr}) : '0;
        g_plus_st  = {1'b0, gravity} + {1'b0, still_thr};
        g_minus_st = (gravity >= still_thr) ? ({1'b0, gravity} - {1'b0, still_thr}) : '0;
        s_ext      = {8'b0, s_reg};
        rhs        = 56'(grz_lo_reg) + {prod_reg[39:0], 16'b0};
        lhs        = {9'b0, sq_x, 16'b0};
        grazing    = x_neg && (lhs > rhs);
        y_ext      = {corr_y[ACC_W-1], corr_y};
        y_abs      = corr_y[ACC_W-1] ? (~y_ext + 1'b1) : y_ext;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step)
            ST_SUM: begin
                mul_a = {12'b0, tangent};
                mul_b = {5'b0, tangent};
            end
            ST_MOVE_HI: begin
                mul_a = {8'b0, g_plus_m};
                mul_b = {1'b0, g_plus_m};
            end
            ST_MOVE_LO: begin
                mul_a = {8'b0, g_minus_m};
                mul_b = {1'b0, g_minus_m};
            end
            ST_STILL_HI: begin
                mul_a = {8'b0, g_plus_st};
                mul_b = {1'b0, g_plus_st};
            end
            ST_STILL_LO: begin
                mul_a = {8'b0, g_minus_st};
                mul_b = {1'b0, g_minus_st};
            end
            ST_GRZ_LO: begin
                mul_a = t2_reg;
                mul_b = {1'b0, yz_reg[15:0]};
            end
            ST_GRZ_HI: begin
                mul_a = t2_reg;
                mul_b = {1'b0, yz_reg[31:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 41'(mul_a) * 41'(mul_b);
    end

    always_comb begin
        s_next      = s_reg;
        yz_next     = yz_reg;
        t2_next     = t2_reg;
        grz_lo_next = grz_lo_reg;
        mv_hi_next  = mv_hi_reg;
        mv_lo_next  = mv_lo_reg;
        st_hi_next  = st_hi_reg;
        st_lo_next  = st_lo_reg;
        code_next   = code_reg;
        case (step)
            ST_SUM: begin
                s_next  = 33'(sq_x) + 33'(sq_y) + 33'(sq_z);
                yz_next = 32'(sq_y) + 32'(sq_z);
            end
            ST_MOVE_HI: begin
                t2_next = prod_reg[23:0];
            end
            ST_MOVE_LO: begin
                mv_hi_next = s_ext > prod_reg;
            end
            ST_STILL_HI: begin
                mv_lo_next = (gravity > move_thr) && (s_ext < prod_reg);
            end
            ST_STILL_LO: begin
                st_hi_next = s_ext < prod_reg;
            end
            ST_GRZ_LO: begin
                st_lo_next = (gravity < still_thr) || (s_ext > prod_reg);
            end
            ST_GRZ_HI: begin
                grz_lo_next = prod_reg[39:0];
            end
            ST_DECIDE: begin
                if (mv_hi_reg || mv_lo_reg) begin
                    code_next = BEH_MOVING;
                end else if (grazing) begin
                    code_next = BEH_GRAZING;
                end else if (st_hi_reg && st_lo_reg && (y_abs > {2'b0, side_thr})) begin
                    code_next = BEH_SIDE;
                end else begin
                    code_next = BEH_STANDING;
                end
            end
            default: begin
                s_next = s_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        s_reg      <= s_next;
        yz_reg     <= yz_next;
        t2_reg     <= t2_next;
        prod_reg   <= prod_next;
        grz_lo_reg <= grz_lo_next;
        mv_hi_reg  <= mv_hi_next;
        mv_lo_reg  <= mv_lo_next;
        st_hi_reg  <= st_hi_next;
        st_lo_reg  <= st_lo_next;
        code_reg   <= code_next;
    end

    assign code = code_reg;

endmodule

>>> sv/accel_posture_activity_classifier_unit.sv
// Posture and activity classifier for three-axis accelerometer samples (Q8 m/s^2).
// Three axis lanes calibrate offsets, correct and square the sample side by side; a
// merge stage with one shared multiplier then tests magnitude and pitch on squares.
// One transfer in, one transfer out, one item at a time. Accept to result register:
// restart request straight to output, calibration sample via accumulate, the sample
// that completes calibration via the reciprocal multiply for the average, calibrated
// sample via correct, square and the seven products of the shared merge multiplier.
// The next item is accepted while a result still waits on m_tready. No clearing pass.
module accel_posture_activity_classifier_unit
    import apac_pkg::*;
#(
    parameter int CAL_SAMPLES = 100
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // accel_x, accel_y, accel_z
    input  logic              s_tuser,   // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // behavior_code, corrected_x, corrected_y,
                                         // corrected_z, zero pad
    output logic              m_tuser,   // calibrated
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [THR_W-1:0]  cfg_wdata
);

    st_t state_reg, state_next;

    logic [THR_W-1:0] gravity_reg, gravity_next;
    logic [THR_W-1:0] move_reg, move_next;
    logic [THR_W-1:0] still_reg, still_next;
    logic [TAN_W-1:0] tangent_reg, tangent_next;
    logic [THR_W-1:0] side_reg, side_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             cal_reg, cal_next;
    logic             res_cls_reg, res_cls_next;

    logic signed [ACC_W-1:0] smp_x_reg, smp_x_next;
    logic signed [ACC_W-1:0] smp_y_reg, smp_y_next;
    logic signed [ACC_W-1:0] smp_z_reg, smp_z_next;

    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;

    logic             accept;
    logic             restart;
    logic             out_free;
    logic             load_out;
    logic [CNT_W-1:0] count_inc;
    lane_ctrl_t       lane_ctrl;

    logic signed [ACC_W-1:0] corr_x, corr_y, corr_z;
    logic [30:0]             sq_x, sq_y, sq_z;
    logic [1:0]              code;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign restart   = accept && s_tuser;
    assign out_free  = !m_valid_reg || m_tready;
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        state_next = ST_OUT;
                    end else if (!cal_reg) begin
                        state_next = ST_CAL_ACC;
                    end else begin
                        state_next = ST_COR;
                    end
                end
            end
            ST_CAL_ACC: begin
                state_next = (count_inc >= CNT_W'(CAL_SAMPLES)) ? ST_CAL_DIV : ST_OUT;
            end
            ST_CAL_DIV:  state_next = ST_CAL_FIN;
            ST_CAL_FIN:  state_next = ST_OUT;
            ST_COR:      state_next = ST_SQR;
            ST_SQR:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_MOVE_HI;
            ST_MOVE_HI:  state_next = ST_MOVE_LO;
            ST_MOVE_LO:  state_next = ST_STILL_HI;
            ST_STILL_HI: state_next = ST_STILL_LO;
            ST_STILL_LO: state_next = ST_GRZ_LO;
            ST_GRZ_LO:   state_next = ST_GRZ_HI;
            ST_GRZ_HI:   state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl     = '0;
        lane_ctrl.clr = restart;
        load_out      = 1'b0;
        case (state_reg)
            ST_CAL_ACC: lane_ctrl.acc = 1'b1;
            ST_CAL_DIV: lane_ctrl.div = 1'b1;
            ST_CAL_FIN: lane_ctrl.fin = 1'b1;
            ST_COR:     lane_ctrl.cor = 1'b1;
            ST_SQR:     lane_ctrl.sqr = 1'b1;
            ST_OUT:     load_out      = out_free;
            default:    load_out      = 1'b0;
        endcase
    end

    always_comb begin
        gravity_next = gravity_reg;
        move_next    = move_reg;
        still_next   = still_reg;
        tangent_next = tangent_reg;
        side_next    = side_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GRAVITY: gravity_next = cfg_wdata;
                REG_MOVE:    move_next    = cfg_wdata;
                REG_STILL:   still_next   = cfg_wdata;
                REG_TANGENT: tangent_next = cfg_wdata[TAN_W-1:0];
                REG_SIDE:    side_next    = cfg_wdata;
                default:     gravity_next = gravity_reg;
            endcase
        end
    end

    always_comb begin
        count_next   = count_reg;
        cal_next     = cal_reg;
        res_cls_next = res_cls_reg;
        smp_x_next   = smp_x_reg;
        smp_y_next   = smp_y_reg;
        smp_z_next   = smp_z_reg;
        if (accept) begin
            smp_x_next   = s_tdata[15:0];
            smp_y_next   = s_tdata[31:16];
            smp_z_next   = s_tdata[47:32];
            res_cls_next = !s_tuser && cal_reg;
        end
        if (restart) begin
            count_next = '0;
            cal_next   = 1'b0;
        end else if (state_reg == ST_CAL_ACC) begin
            count_next = count_inc;
        end else if (state_reg == ST_CAL_FIN) begin
            count_next = '0;
            cal_next   = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_user_next  = res_cls_reg;
            m_data_next  = res_cls_reg ? {6'b0, corr_z, corr_y, corr_x, code} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gravity_reg <= GRAVITY_RST;
            move_reg    <= MOVE_RST;
            still_reg   <= STILL_RST;
            tangent_reg <= TANGENT_RST;
            side_reg    <= SIDE_RST;
            count_reg   <= '0;
            cal_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gravity_reg <= gravity_next;
            move_reg    <= move_next;
            still_reg   <= still_next;
            tangent_reg <= tangent_next;
            side_reg    <= side_next;
            count_reg   <= count_next;
            cal_reg     <= cal_next;
            m_valid_reg <= m_valid_next;
        end
        res_cls_reg <= res_cls_next;
        smp_x_reg   <= smp_x_next;
        smp_y_reg   <= smp_y_next;
        smp_z_reg   <= smp_z_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    apac_axis_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .sample  (smp_x_reg),
        .bias    ('0),
        .corr    (corr_x),
        .sq      (sq_x)
    );

    apac_axis_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .sample  (smp_y_reg),
        .bias    ('0),
        .corr    (corr_y),
        .sq      (sq_y)
    );

    // z offset carries gravity out
    apac_axis_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .sample  (smp_z_reg),
        .bias    (gravity_reg),
        .corr    (corr_z),
        .sq      (sq_z)
    );

    apac_merge u_merge (
        .aclk      (aclk),
        .step      (state_reg),
        .sq_x      (sq_x),
        .sq_y      (sq_y),
        .sq_z      (sq_z),
        .x_neg     (corr_x[ACC_W-1]),
        .corr_y    (corr_y),
        .gravity   (gravity_reg),
        .move_thr  (move_reg),
        .still_thr (still_reg),
        .tangent   (tangent_reg),
        .side_thr  (side_reg),
        .code      (code)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> sv/apac_checker.sv
module apac_checker
    import apac_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // one item in flight: busy right after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("uncalibrated result carries data");

    // grazing needs a nose-down pitch, so corrected x is negative
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (m_tdata[1:0] == BEH_GRAZING) |-> m_tdata[17])
        else $error("grazing with non-negative x");

endmodule

bind accel_posture_activity_classifier_unit apac_checker u_apac_checker (.*);

>>> tb/accel_posture_activity_classifier_unit_tb.sv
module accel_posture_activity_classifier_unit_tb;
    import apac_pkg::*;

    localparam int CAL_N       = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 16;

    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {
        POSE_STAND,
        POSE_SIDE,
        POSE_GRAZE,
        POSE_TILT,
        POSE_MOVE,
        POSE_EDGE,
        POSE_NOISE
    } pose_t;

    typedef struct packed {
        logic              calibrated;
        logic [1:0]        behavior;
        logic [ACC_W-1:0]  cx;
        logic [ACC_W-1:0]  cy;
        logic [ACC_W-1:0]  cz;
    } posture_result_t;

    class posture_scoreboard;
        int grav, move_thr, still_thr, tangent, side_thr;
        int sum_x, sum_y, sum_z;
        int cal_cnt;
        int off_x, off_y, off_z;
        bit cal_done;
        posture_result_t pending_postures[$];
        int mismatches;

        function new();
            grav      = GRAVITY_RST;
            move_thr  = MOVE_RST;
            still_thr = STILL_RST;
            tangent   = TANGENT_RST;
            side_thr  = SIDE_RST;
            off_x = 0;
            off_y = 0;
            off_z = 0;
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
            cal_cnt = 0;
            cal_done = 0;
            mismatches = 0;
        endfunction

        function int sat16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // nearest, ties away from zero
        function int avg_round(int s);
            int mag;
            mag = (s < 0) ? -s : s;
            mag = (mag + CAL_N / 2) / CAL_N;
            return (s < 0) ? -mag : mag;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [THR_W-1:0] v);
            case (idx)
                REG_GRAVITY: grav = v;
                REG_MOVE:    move_thr = v;
                REG_STILL:   still_thr = v;
                REG_TANGENT: tangent = v[TAN_W-1:0];
                REG_SIDE:    side_thr = v;
                default: ;
            endcase
        endfunction

        function logic [1:0] classify_posture(int x, int y, int z);
            longint s, yz, g, m, st, t;
            bit moving, still;
            int abs_y;
            yz = longint'(y) * y + longint'(z) * z;
            s  = longint'(x) * x + yz;
            g  = grav;
            m  = move_thr;
            st = still_thr;
            t  = tangent;
            moving = (s > (g + m) * (g + m)) || (g > m && s < (g - m) * (g - m));
            still  = (s < (g + st) * (g + st)) && (g < st || s > (g - st) * (g - st));
            abs_y  = (y < 0) ? -y : y;
            if (moving) return BEH_MOVING;
            if (x < 0 && ((longint'(x) * x) << 16) > t * t * yz) return BEH_GRAZING;
            if (still && abs_y > side_thr) return BEH_SIDE;
            return BEH_STANDING;
        endfunction

        function void take_sample(bit restart, int ax, int ay, int az);
            posture_result_t r;
            int cx, cy, cz;
            r = '0;
            if (restart) begin
                sum_x = 0;
                sum_y = 0;
                sum_z = 0;
                cal_cnt = 0;
                cal_done = 0;
            end else if (!cal_done) begin
                sum_x += ax;
                sum_y += ay;
                sum_z += az;
                cal_cnt = (cal_cnt + 1) & 127;
                if (cal_cnt >= CAL_N) begin
                    off_x = avg_round(sum_x);
                    off_y = avg_round(sum_y);
                    off_z = sat16(avg_round(sum_z) - grav);
                    cal_cnt = 0;
                    cal_done = 1;
                end
            end else begin
                cx = sat16(ax - off_x);
                cy = sat16(ay - off_y);
                cz = sat16(az - off_z);
                r.calibrated = 1'b1;
                r.behavior   = classify_posture(cx, cy, cz);
                r.cx = cx[ACC_W-1:0];
                r.cy = cy[ACC_W-1:0];
                r.cz = cz[ACC_W-1:0];
            end
            pending_postures.push_back(r);
        endfunction

        function void flag(string what, int want_v, int got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
        endfunction

        function void check_posture(logic user, logic [55:0] data);
            posture_result_t want;
            if (pending_postures.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: result transfer with nothing pending");
                return;
            end
            want = pending_postures.pop_front();
            if (user !== want.calibrated)
                flag("calibrated", want.calibrated, user);
            if (data[1:0] !== want.behavior)
                flag("behavior_code", want.behavior, data[1:0]);
            if (data[17:2] !== want.cx)
                flag("corrected_x", $signed(want.cx), $signed(data[17:2]));
            if (data[33:18] !== want.cy)
                flag("corrected_y", $signed(want.cy), $signed(data[33:18]));
            if (data[49:34] !== want.cz)
                flag("corrected_z", $signed(want.cz), $signed(data[49:34]));
        endfunction

        function void close_out();
            if (pending_postures.size() != 0) begin
                $display("%0d results never arrived", pending_postures.size());
                mismatches += pending_postures.size();
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;   // accel_x, accel_y, accel_z
    logic                s_tuser   = 1'b0; // req_type
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [55:0]         m_tdata;          // behavior_code, corrected_x, corrected_y,
                                           // corrected_z, zero pad
    logic                m_tuser;          // calibrated
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr  = '0;
    logic [THR_W-1:0]    cfg_wdata = '0;

    posture_scoreboard sb;
    bit steady = 1'b0;
    int sent_count = 0;

    accel_posture_activity_classifier_unit #(
        .CAL_SAMPLES(CAL_N)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 1000000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic signed [ACC_W-1:0] clip16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[ACC_W-1:0];
    endfunction

    function automatic int jit(int w);
        if (w <= 0) return 0;
        return int'($urandom_range(2 * w, 0)) - w;
    endfunction

    function automatic int rnd16();
        return int'($urandom_range(65535, 0)) - 32768;
    endfunction

    task automatic send_item(bit restart, int ax, int ay, int az);
        logic signed [ACC_W-1:0] vx, vy, vz;
        vx = clip16(ax);
        vy = clip16(ay);
        vz = clip16(az);
        sent_count++;
        steady = (sent_count >= 600 && sent_count < 800);
        while (!steady && $urandom_range(99, 0) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= {vz, vy, vx};
        do @(posedge aclk); while (!s_tready);
        sb.take_sample(restart, int'(vx), int'(vy), int'(vz));
    endtask

    task automatic calibrate(bit restart_first, int bx, int by, int bz, int spread);
        if (restart_first) send_item(1'b1, rnd16(), rnd16(), rnd16());
        repeat (CAL_N) send_item(1'b0, bx + jit(spread), by + jit(spread), bz + jit(spread));
    endtask

    task automatic send_posture();
        int g, m, st, w, cx, cy, cz, d;
        pose_t kind;
        g  = sb.grav;
        m  = sb.move_thr;
        st = sb.still_thr;
        w  = st / 2 + 4;
        cx = jit(w);
        cy = jit(w);
        cz = g + jit(w);
        case ($urandom_range(9, 0))
            0, 1:    kind = POSE_STAND;
            2, 3:    kind = POSE_SIDE;
            4:       kind = POSE_GRAZE;
            5:       kind = POSE_TILT;
            6:       kind = POSE_MOVE;
            7:       kind = POSE_EDGE;
            default: kind = POSE_NOISE;
        endcase
        case (kind)
            POSE_SIDE: begin
                cy = ($urandom_range(1, 0) ? 1 : -1) * (g + jit(w));
                cz = jit(w);
            end
            POSE_GRAZE: begin
                cx = -(g * 3 / 5) + jit(w);
                cz = g * 4 / 5 + jit(w);
            end
            POSE_TILT: begin
                cx = -int'($urandom_range(g, 0));
                cz = g;
            end
            POSE_MOVE: begin
                cx = jit(g);
                cy = jit(g);
                d  = m + 1 + int'($urandom_range(2000, 0));
                cz = $urandom_range(1, 0) ? g + d : g - d;
            end
            POSE_EDGE: begin
                cx = 0;
                cy = 0;
                case ($urandom_range(3, 0))
                    0: d = m;
                    1: d = -m;
                    2: d = st;
                    default: d = -st;
                endcase
                cz = g + d + jit(1);
            end
            POSE_NOISE: begin
                cx = rnd16() - sb.off_x;
                cy = rnd16() - sb.off_y;
                cz = rnd16() - sb.off_z;
            end
            default: ;
        endcase
        send_item(1'b0, cx + sb.off_x, cy + sb.off_y, cz + sb.off_z);
    endtask

    task automatic run_random(int n);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(249, 0) == 0) begin
                if ($urandom_range(1, 0))
                    calibrate(1'b1, rnd16(), rnd16(), rnd16(), $urandom_range(2000, 0));
                else
                    calibrate(1'b1, jit(300), jit(300), sb.grav + jit(300), 50);
                k += CAL_N + 1;
            end else begin
                send_posture();
                k++;
            end
        end
    endtask

    task automatic drain();
        int k;
        s_tvalid <= 1'b0;
        for (k = 0; k < 5000 && sb.pending_postures.size() != 0; k++) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_one(logic [CFG_AW-1:0] idx, int v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v[THR_W-1:0];
        @(posedge aclk);
        sb.write_reg(idx, v[THR_W-1:0]);
    endtask

    task automatic program_regs(int g, int m, int st, int t, int sd);
        write_one(REG_GRAVITY, g);
        write_one(REG_MOVE, m);
        write_one(REG_STILL, st);
        write_one(REG_TANGENT, t);
        write_one(REG_SIDE, sd);
        // unmapped index, must have no effect
        write_one($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int seen;
        bit held;
        seen = 0;
        held = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_posture(m_tuser, m_tdata);
                seen++;
            end
            if (!held && seen == HOLD_AT) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99, 0) >= 38);
            end
        end
    end

    initial begin
        int k;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults, exact offsets of zero
        calibrate(1'b0, 0, 0, GRAVITY_RST, 0);
        send_item(1'b0, 32767, 32767, 32767);
        send_item(1'b0, -32768, -32768, -32768);
        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 0, 0, 2511);
        send_item(1'b0, 0, 2511, 0);
        send_item(1'b0, 0, -2511, 0);
        send_item(1'b0, -1100, 0, 2260);
        send_item(1'b0, 1100, 0, 2260);
        send_item(1'b0, 0, 0, 5000);
        send_item(1'b0, 0, 0, 1000);
        send_item(1'b0, 0, 0, 2511 + 461);
        send_item(1'b0, 0, 0, 2511 - 461);
        send_item(1'b0, 0, 0, -2511);
        send_item(1'b0, -32768, 0, 0);
        send_item(1'b1, -32768, 32767, -1);
        calibrate(1'b0, 0, 0, GRAVITY_RST, 20);
        run_random(150);

        // all registers at their top values
        drain();
        program_regs(32767, 32767, 32767, 32767, 32767);
        send_item(1'b1, 0, 0, 0);
        for (k = 0; k < 37; k++) send_posture();
        send_item(1'b1, 0, 0, 0);
        // rounding ties on each axis, z offset saturates
        send_item(1'b0, 50, -150, -250);
        repeat (CAL_N - 1) send_item(1'b0, 0, 0, 0);
        run_random(100);
        calibrate(1'b1, 0, 0, -32768, 0);
        run_random(100);

        // all registers at zero
        drain();
        program_regs(0, 0, 0, 0, 0);
        calibrate(1'b1, rnd16(), rnd16(), rnd16(), 1000);
        run_random(100);

        repeat (3) begin
            drain();
            program_regs($urandom_range(3000, 2000), $urandom_range(800, 100),
                         $urandom_range(200, 10), $urandom_range(400, 0),
                         $urandom_range(2500, 1000));
            calibrate(1'b1, jit(400), jit(400), sb.grav + jit(400), 60);
            run_random(50);
        end

        drain();
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        calibrate(1'b1, rnd16(), rnd16(), rnd16(), $urandom_range(5000, 0));
        run_random(50);

        drain();
        sb.close_out();
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/apac_pkg.sv
sv/apac_axis_lane.sv
sv/apac_merge.sv
sv/accel_posture_activity_classifier_unit.sv
sv/apac_checker.sv
tb/accel_posture_activity_classifier_unit_tb.sv
